[design/srts_pkg.sv]
`timescale 1ns / 1ps

package srts_pkg;

  localparam int SRTS_TABLE_DEPTH = 32;
  localparam int SRTS_STD_COUNT   = 10;
  localparam logic [23:0] SRTS_FAM_44K = 24'd44100;
  localparam logic [23:0] SRTS_FAM_48K = 24'd48000;

  // Rounded-up reciprocals scaled by 2^40. For any 24-bit rate the top bits of
  // rate times reciprocal give the exact quotient by the family base.
  localparam logic [24:0] SRTS_RCP_44K = 25'((64'd1 << 40) / 64'd44100 + 64'd1);
  localparam logic [24:0] SRTS_RCP_48K = 25'((64'd1 << 40) / 64'd48000 + 64'd1);

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_DISC = 2'd1,
    OP_ADD_RNG  = 2'd2,
    OP_FIND     = 2'd3
  } srts_op_t;

  // One table word: rate in hertz and its clock source id.
  typedef struct packed {
    logic [23:0] rate;
    logic [7:0]  clk;
  } srts_entry_t;

  // Start request to the serial remainder unit.
  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [23:0] divisor;
  } srts_div_req_t;

  // Completion status of the serial remainder unit.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } srts_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAMQ,
    ST_FAMQ_W,
    ST_RD,
    ST_CMP,
    ST_FAM_W,
    ST_TAIL,
    ST_RNG,
    ST_RNG_W,
    ST_DONE
  } srts_state_t;

  // Standard rates scanned by add range.
  function automatic logic [23:0] std_rate(input logic [3:0] k);
    logic [23:0] r;
    case (k)
      4'd0: r = 24'd44100;
      4'd1: r = 24'd48000;
      4'd2: r = 24'd88200;
      4'd3: r = 24'd96000;
      4'd4: r = 24'd176400;
      4'd5: r = 24'd192000;
      4'd6: r = 24'd352800;
      4'd7: r = 24'd384000;
      4'd8: r = 24'd705600;
      4'd9: r = 24'd768000;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

[design/srts_if.sv]
`timescale 1ns / 1ps

// Input channel: one operation per beat.
interface srts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [23:0] range_low;
  logic [23:0] range_high;
  logic [23:0] resolution;
  logic [7:0]  clock_id;
  logic [23:0] requested_rate;

  modport source (output valid, operation, range_low, range_high, resolution,
                  clock_id, requested_rate, input ready);
  modport sink (input valid, operation, range_low, range_high, resolution,
                clock_id, requested_rate, output ready);
endinterface

// Result channel: one result beat per input beat.
interface srts_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] best_rate;
  logic        exact_match;
  logic [7:0]  chosen_clock;
  logic        dropped;
  logic [5:0]  entry_total;

  modport source (output valid, best_rate, exact_match, chosen_clock, dropped,
                  entry_total, input ready);
  modport sink (input valid, best_rate, exact_match, chosen_clock, dropped,
                entry_total, output ready);
endinterface

[design/srts_div.sv]
`timescale 1ns / 1ps

// Restoring remainder unit, one quotient bit per cycle.
module srts_div
  import srts_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  srts_div_req_t req,
  output srts_div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [23:0] dvd_r, dvd_nxt;
  logic [23:0] dvs_r, dvs_nxt;
  logic [24:0] trial;

  // One shift and conditional subtract per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, dvd_r[23]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd23;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 24'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[23:0];
      end
      dvd_nxt = {dvd_r[22:0], 1'b0};
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == 24'd0);

endmodule

[design/srts_mem.sv]
`timescale 1ns / 1ps

// Rate table storage: one write port, one registered read port.
module srts_mem
  import srts_pkg::*;
#(
  parameter int DEPTH = SRTS_TABLE_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  srts_entry_t   wdata,
  input  logic [AW-1:0] raddr,
  output srts_entry_t   rdata
);

  srts_entry_t mem [DEPTH];
  srts_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/sample_rate_table_select_top.sv]
`timescale 1ns / 1ps

// Sorted sample rate table with best-rate lookup. The table lives in one
// single-port-write memory with a registered read; each item is handled
// alone by a sequencer that walks the table one entry at a time. Clear
// empties the table at once; an insert reads each entry in turn, shifting
// later entries up as it passes; add range skips each standard rate
// outside the range and repeats the insert for each one inside, with a
// serial remainder check per rate when resolution is nonzero; find best
// first tests the family of the requested rate, then reads each entry and
// tests its family by a registered reciprocal multiply. A new item is
// taken while the previous result still waits on the output; the result
// leaves once the output register is free.
module sample_rate_table_select_top
  import srts_pkg::*;
#(
  parameter int TABLE_DEPTH = SRTS_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  srts_in_if.sink    in_ch,
  srts_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  srts_state_t state_r, state_nxt;

  logic [7:0]    dflt_clk_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [3:0]    k_r, k_nxt;

  // Latched input beat.
  srts_op_t    op_r, op_nxt;
  logic [23:0] lo_r, lo_nxt;
  logic [23:0] hi_r, hi_nxt;
  logic [23:0] res_r, res_nxt;
  logic [7:0]  iclk_r, iclk_nxt;
  logic [23:0] req_r, req_nxt;

  // Insert context.
  logic        rng_mode_r, rng_mode_nxt;
  logic        placed_r, placed_nxt;
  srts_entry_t ins_r, ins_nxt;
  srts_entry_t carry_r, carry_nxt;
  logic        drop_r, drop_nxt;

  // Find context.
  logic [23:0] fam_mod_r, fam_mod_nxt;
  srts_entry_t cur_r, cur_nxt;
  logic        all_v_r, all_v_nxt;
  logic [23:0] all_d_r, all_d_nxt;
  srts_entry_t all_e_r, all_e_nxt;
  logic        fam_v_r, fam_v_nxt;
  logic [23:0] fam_d_r, fam_d_nxt;
  srts_entry_t fam_e_r, fam_e_nxt;

  // Family test: quotient register and its check.
  logic [8:0]  fam_q_r, fam_q_nxt;
  logic [23:0] fam_x;
  logic [24:0] fam_m;
  logic [48:0] fam_prod;
  logic [23:0] fam_div;
  logic [23:0] fam_tgt;
  logic [32:0] fam_qd;
  logic        fam_hit;

  // Output register.
  logic        ov_r, ov_nxt;
  logic [23:0] o_rate_r, o_rate_nxt;
  logic        o_exact_r, o_exact_nxt;
  logic [7:0]  o_clk_r, o_clk_nxt;
  logic        o_drop_r, o_drop_nxt;
  logic [5:0]  o_total_r, o_total_nxt;

  // Memory and divider hookup.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  srts_entry_t   mem_wdata;
  srts_entry_t   mem_rdata;
  srts_div_req_t div_req;
  srts_div_rsp_t div_rsp;

  logic          full;
  logic [23:0]   srate;
  logic [23:0]   cur_d;
  srts_entry_t   sel_e;
  logic [31:0]   count_wide;

  srts_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  srts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign full       = (count_r >= CW'(TABLE_DEPTH));
  assign srate      = std_rate(k_r);
  assign cur_d      = (req_r > cur_r.rate) ? (req_r - cur_r.rate) : (cur_r.rate - req_r);
  assign count_wide = 32'(count_r);
  assign sel_e      = (all_d_r == 24'd0 || !fam_v_r) ? all_e_r : fam_e_r;

  // First step of the family test: quotient by reciprocal multiply.
  assign fam_x     = (state_r == ST_FAMQ) ? req_r : mem_rdata.rate;
  assign fam_m     = (state_r == ST_FAMQ || fam_mod_r == SRTS_FAM_44K) ?
                     SRTS_RCP_44K : SRTS_RCP_48K;
  assign fam_prod  = 49'(fam_x) * 49'(fam_m);
  assign fam_q_nxt = fam_prod[48:40];

  // Second step: the rate is in the family when quotient times base gives it back.
  assign fam_div = (state_r == ST_FAMQ_W) ? SRTS_FAM_44K : fam_mod_r;
  assign fam_tgt = (state_r == ST_FAMQ_W) ? req_r : cur_r.rate;
  assign fam_qd  = 33'(fam_q_r) * 33'(fam_div);
  assign fam_hit = (fam_qd == 33'(fam_tgt));

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.best_rate   = o_rate_r;
  assign out_ch.exact_match = o_exact_r;
  assign out_ch.chosen_clock = o_clk_r;
  assign out_ch.dropped     = o_drop_r;
  assign out_ch.entry_total = o_total_r;

  // Sequencer: next state, memory and divider control.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    op_nxt       = op_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    res_nxt      = res_r;
    iclk_nxt     = iclk_r;
    req_nxt      = req_r;
    rng_mode_nxt = rng_mode_r;
    placed_nxt   = placed_r;
    ins_nxt      = ins_r;
    carry_nxt    = carry_r;
    drop_nxt     = drop_r;
    fam_mod_nxt  = fam_mod_r;
    cur_nxt      = cur_r;
    all_v_nxt    = all_v_r;
    all_d_nxt    = all_d_r;
    all_e_nxt    = all_e_r;
    fam_v_nxt    = fam_v_r;
    fam_d_nxt    = fam_d_r;
    fam_e_nxt    = fam_e_r;
    ov_nxt       = ov_r;
    o_rate_nxt   = o_rate_r;
    o_exact_nxt  = o_exact_r;
    o_clk_nxt    = o_clk_r;
    o_drop_nxt   = o_drop_r;
    o_total_nxt  = o_total_r;
    mem_we       = 1'b0;
    mem_waddr    = idx_r[AW-1:0];
    mem_wdata    = ins_r;
    div_req      = '0;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = srts_op_t'(in_ch.operation);
          lo_nxt     = in_ch.range_low;
          hi_nxt     = in_ch.range_high;
          res_nxt    = in_ch.resolution;
          iclk_nxt   = in_ch.clock_id;
          req_nxt    = in_ch.requested_rate;
          drop_nxt   = 1'b0;
          all_v_nxt  = 1'b0;
          fam_v_nxt  = 1'b0;
          placed_nxt = 1'b0;
          idx_nxt    = '0;
          k_nxt      = '0;
          ins_nxt.rate = in_ch.range_low;
          ins_nxt.clk  = in_ch.clock_id;
          rng_mode_nxt = 1'b0;
          case (srts_op_t'(in_ch.operation))
            OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
            OP_ADD_DISC: begin
              state_nxt = (count_r == '0) ? ST_TAIL : ST_RD;
            end
            OP_ADD_RNG: begin
              if (in_ch.range_low == in_ch.range_high) begin
                state_nxt = (count_r == '0) ? ST_TAIL : ST_RD;
              end else begin
                rng_mode_nxt = 1'b1;
                state_nxt    = ST_RNG;
              end
            end
            OP_FIND: begin
              state_nxt = ST_FAMQ;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      // Family of the requested rate: quotient is registered this cycle.
      ST_FAMQ: begin
        state_nxt = ST_FAMQ_W;
      end

      ST_FAMQ_W: begin
        fam_mod_nxt = fam_hit ? SRTS_FAM_44K : SRTS_FAM_48K;
        state_nxt   = (count_r == '0) ? ST_DONE : ST_RD;
      end

      // Read address is idx_r; data shows up next cycle.
      ST_RD: begin
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        if (op_r == OP_FIND) begin
          cur_nxt   = mem_rdata;
          state_nxt = ST_FAM_W;
        end else if (!placed_r) begin
          if (mem_rdata.rate == ins_r.rate) begin
            state_nxt = rng_mode_r ? ST_RNG : ST_DONE;
            k_nxt     = rng_mode_r ? (k_r + 4'd1) : k_r;
          end else if (mem_rdata.rate > ins_r.rate) begin
            if (full) begin
              drop_nxt  = 1'b1;
              state_nxt = rng_mode_r ? ST_RNG : ST_DONE;
              k_nxt     = rng_mode_r ? (k_r + 4'd1) : k_r;
            end else begin
              mem_we     = 1'b1;
              mem_wdata  = ins_r;
              carry_nxt  = mem_rdata;
              placed_nxt = 1'b1;
              idx_nxt    = idx_r + CW'(1);
              state_nxt  = (idx_r + CW'(1) == count_r) ? ST_TAIL : ST_RD;
            end
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = (idx_r + CW'(1) == count_r) ? ST_TAIL : ST_RD;
          end
        end else begin
          // Shift the displaced entry up by one.
          mem_we    = 1'b1;
          mem_wdata = carry_r;
          carry_nxt = mem_rdata;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = (idx_r + CW'(1) == count_r) ? ST_TAIL : ST_RD;
        end
      end

      // Nearest-entry tracking for find best.
      ST_FAM_W: begin
        if (!all_v_r || cur_d < all_d_r) begin
          all_v_nxt = 1'b1;
          all_d_nxt = cur_d;
          all_e_nxt = cur_r;
        end
        if (fam_hit && (!fam_v_r || cur_d < fam_d_r)) begin
          fam_v_nxt = 1'b1;
          fam_d_nxt = cur_d;
          fam_e_nxt = cur_r;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = (idx_r + CW'(1) == count_r) ? ST_DONE : ST_RD;
      end

      // End of the table: append the new or displaced entry, or drop the new one when the table is full.
      ST_TAIL: begin
        if (!placed_r && full) begin
          drop_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = count_r[AW-1:0];
          mem_wdata = placed_r ? carry_r : ins_r;
          count_nxt = count_r + CW'(1);
        end
        state_nxt = rng_mode_r ? ST_RNG : ST_DONE;
        k_nxt     = rng_mode_r ? (k_r + 4'd1) : k_r;
      end

      // Walk the standard rates for add range.
      ST_RNG: begin
        if (k_r == 4'(SRTS_STD_COUNT)) begin
          state_nxt = ST_DONE;
        end else if (srate < lo_r || srate > hi_r) begin
          k_nxt = k_r + 4'd1;
        end else if (res_r == 24'd0) begin
          ins_nxt.rate = srate;
          ins_nxt.clk  = iclk_r;
          placed_nxt   = 1'b0;
          idx_nxt      = '0;
          state_nxt    = (count_r == '0) ? ST_TAIL : ST_RD;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = srate - lo_r;
          div_req.divisor  = res_r;
          state_nxt        = ST_RNG_W;
        end
      end

      ST_RNG_W: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_zero) begin
            ins_nxt.rate = srate;
            ins_nxt.clk  = iclk_r;
            placed_nxt   = 1'b0;
            idx_nxt      = '0;
            state_nxt    = (count_r == '0) ? ST_TAIL : ST_RD;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = ST_RNG;
          end
        end
      end

      // Load the result beat once the output register is free.
      ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt      = 1'b1;
          o_drop_nxt  = drop_r;
          o_total_nxt = count_wide[5:0];
          o_rate_nxt  = '0;
          o_exact_nxt = 1'b0;
          o_clk_nxt   = '0;
          if (op_r == OP_FIND && all_v_r) begin
            o_rate_nxt  = sel_e.rate;
            o_exact_nxt = (all_d_r == 24'd0);
            o_clk_nxt   = (sel_e.clk == 8'd0) ? dflt_clk_r : sel_e.clk;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      ov_r       <= 1'b0;
      dflt_clk_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        dflt_clk_r <= cfg_wdata;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    op_r       <= op_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    res_r      <= res_nxt;
    iclk_r     <= iclk_nxt;
    req_r      <= req_nxt;
    rng_mode_r <= rng_mode_nxt;
    placed_r   <= placed_nxt;
    ins_r      <= ins_nxt;
    carry_r    <= carry_nxt;
    drop_r     <= drop_nxt;
    fam_mod_r  <= fam_mod_nxt;
    fam_q_r    <= fam_q_nxt;
    cur_r      <= cur_nxt;
    all_v_r    <= all_v_nxt;
    all_d_r    <= all_d_nxt;
    all_e_r    <= all_e_nxt;
    fam_v_r    <= fam_v_nxt;
    fam_d_r    <= fam_d_nxt;
    fam_e_r    <= fam_e_nxt;
    o_rate_r   <= o_rate_nxt;
    o_exact_r  <= o_exact_nxt;
    o_clk_r    <= o_clk_nxt;
    o_drop_r   <= o_drop_nxt;
    o_total_r  <= o_total_nxt;
  end

endmodule

[sim/srts_tb_if.sv]
`timescale 1ns / 1ps

// The channel interfaces come with the design in srts_if.sv; this file only
// gathers the command and result records that the bench keeps for each beat.
package srts_tb_pkg;
  import srts_pkg::*;

  typedef struct packed {
    srts_op_t    op;
    logic [23:0] lo;
    logic [23:0] hi;
    logic [23:0] res;
    logic [7:0]  cid;
    logic [23:0] req;
  } rate_cmd_t;

  typedef struct packed {
    logic [23:0] best_rate;
    logic        exact_match;
    logic [7:0]  chosen_clock;
    logic        dropped;
    logic [5:0]  entry_total;
  } rate_result_t;
endpackage

[sim/sample_rate_table_select_top_tb.sv]
`timescale 1ns / 1ps

module sample_rate_table_select_top_tb;
  import srts_pkg::*;
  import srts_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  srts_in_if  in_ch ();
  srts_out_if out_ch ();

  sample_rate_table_select_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: sorted rates with their clock ids.
  logic [23:0] tbl_rate [SRTS_TABLE_DEPTH];
  logic [7:0]  tbl_clk  [SRTS_TABLE_DEPTH];
  int          tbl_count;
  logic [7:0]  dflt_clock;

  rate_result_t pending_results[$];
  int errors = 0;
  int mismatches = 0;
  bit rx_stall_mode = 1'b0;

  // Insert one rate; returns 1 when a new rate found the table full.
  function automatic bit table_insert(input logic [23:0] rate, input logic [7:0] cid);
    int pos;
    pos = 0;
    while (pos < tbl_count && tbl_rate[pos] < rate) pos++;
    if (pos < tbl_count && tbl_rate[pos] == rate) return 1'b0;
    if (tbl_count >= SRTS_TABLE_DEPTH) return 1'b1;
    for (int i = tbl_count; i > pos; i--) begin
      tbl_rate[i] = tbl_rate[i-1];
      tbl_clk[i]  = tbl_clk[i-1];
    end
    tbl_rate[pos] = rate;
    tbl_clk[pos]  = cid;
    tbl_count++;
    return 1'b0;
  endfunction

  // Closest entry, optionally restricted to one rate family.
  function automatic int nearest_entry(input logic [23:0] req, input int fam);
    int best;
    int unsigned best_d, d;
    best = -1;
    best_d = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (fam != 0 && (tbl_rate[i] % fam) != 0) continue;
      d = 32'((req > tbl_rate[i]) ? req - tbl_rate[i] : tbl_rate[i] - req);
      if (best < 0 || d < best_d) begin
        best = i;
        best_d = d;
      end
    end
    return best;
  endfunction

  function automatic rate_result_t predict_rate_result(input rate_cmd_t c);
    rate_result_t r;
    int idx;
    int unsigned sr;
    r = '0;
    case (c.op)
      OP_CLEAR: tbl_count = 0;
      OP_ADD_DISC: r.dropped = table_insert(c.lo, c.cid);
      OP_ADD_RNG: begin
        if (c.lo == c.hi) begin
          r.dropped = table_insert(c.lo, c.cid);
        end else begin
          for (int k = 0; k < SRTS_STD_COUNT; k++) begin
            sr = 32'(std_rate(k[3:0]));
            if (sr < c.lo || sr > c.hi) continue;
            if (c.res != 0 && ((sr - c.lo) % c.res) != 0) continue;
            if (table_insert(sr[23:0], c.cid)) r.dropped = 1'b1;
          end
        end
      end
      default: begin
        idx = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_rate[i] == c.req) begin
            idx = i;
            r.exact_match = 1'b1;
            break;
          end
        end
        if (idx < 0)
          idx = nearest_entry(c.req, (c.req % SRTS_FAM_44K) == 0 ? 44100 : 48000);
        if (idx < 0) idx = nearest_entry(c.req, 0);
        if (idx >= 0) begin
          r.best_rate = tbl_rate[idx];
          r.chosen_clock = (tbl_clk[idx] == 0) ? dflt_clock : tbl_clk[idx];
        end
      end
    endcase
    r.entry_total = tbl_count[5:0];
    return r;
  endfunction

  // Send one beat, after an idle gap given by the caller to mimic bursty traffic.
  task automatic send_cmd(input rate_cmd_t c, input int gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= c.op;
    in_ch.range_low      <= c.lo;
    in_ch.range_high     <= c.hi;
    in_ch.resolution     <= c.res;
    in_ch.clock_id       <= c.cid;
    in_ch.requested_rate <= c.req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results = {pending_results, predict_rate_result(c)};
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_default_clock(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dflt_clock = v;
    @(posedge clk);
  endtask

  // Receiver: stalls follow their own pattern, calm or heavy by phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    rate_result_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.best_rate, out_ch.exact_match, out_ch.chosen_clock,
             out_ch.dropped, out_ch.entry_total};
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_results.pop_front();
        if (want !== got) begin
          errors++;
          if (mismatches++ < 10)
            $display({"result mismatch: expected rate %0d exact %0b clk %0d drop %0b ",
                      "total %0d, got rate %0d exact %0b clk %0d drop %0b total %0d"},
                     want.best_rate, want.exact_match, want.chosen_clock, want.dropped,
                     want.entry_total, got.best_rate, got.exact_match, got.chosen_clock,
                     got.dropped, got.entry_total);
        end
      end
    end
  end

  function automatic rate_cmd_t mk(input srts_op_t op, input int lo, input int hi,
                                   input int res, input int cid, input int req);
    rate_cmd_t c;
    c.op = op;
    c.lo = lo[23:0];
    c.hi = hi[23:0];
    c.res = res[23:0];
    c.cid = cid[7:0];
    c.req = req[23:0];
    return c;
  endfunction

  // Random rate biased toward standard values and their neighbors.
  function automatic logic [23:0] pick_rate();
    int unsigned s;
    case ($urandom_range(0, 5))
      0: return 24'($urandom());
      1: return 24'($urandom_range(0, 1000));
      2: begin
        s = 32'(std_rate(4'($urandom_range(0, 9))));
        return 24'(s + $urandom_range(0, 40) - 20);
      end
      default: return std_rate(4'($urandom_range(0, 9)));
    endcase
  endfunction

  function automatic rate_cmd_t random_cmd();
    rate_cmd_t c;
    int sel;
    c = '0;
    c.hi = 24'($urandom());
    c.res = 24'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 3) c.op = OP_CLEAR;
    else if (sel < 35) c.op = OP_ADD_DISC;
    else if (sel < 50) c.op = OP_ADD_RNG;
    else c.op = OP_FIND;
    c.lo = pick_rate();
    c.req = pick_rate();
    c.cid = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom());
    if (c.op == OP_ADD_RNG) begin
      case ($urandom_range(0, 4))
        0: c.hi = c.lo;
        1: c.hi = 24'($urandom());
        default: c.hi = 24'(c.lo + $urandom_range(0, 800000));
      endcase
      case ($urandom_range(0, 3))
        0: c.res = 24'd0;
        1: c.res = 24'($urandom());
        default: c.res = 24'(($urandom_range(1, 5) << 8) + 300);
      endcase
    end
    return c;
  endfunction

  // Directed table: the expected result is typed where it is obvious.
  typedef struct {
    rate_cmd_t    cmd;
    bit           typed;
    rate_result_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(input rate_cmd_t cmd, input bit typed,
                                  input rate_result_t want);
    dir_row_t r;
    r.cmd = cmd;
    r.typed = typed;
    r.want = want;
    dir_rows = {dir_rows, r};
  endfunction

  initial begin
    rate_cmd_t c;
    int sent;
    int burst;

    in_ch.valid = 1'b0;
    in_ch.operation = OP_CLEAR;
    in_ch.range_low = '0;
    in_ch.range_high = '0;
    in_ch.resolution = '0;
    in_ch.clock_id = '0;
    in_ch.requested_rate = '0;
    tbl_count = 0;
    dflt_clock = 8'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mk(OP_FIND, 0, 0, 0, 0, 48000), 1, '{0, 0, 0, 0, 0});
    add_row(mk(OP_ADD_DISC, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 1});
    add_row(mk(OP_ADD_DISC, 24'hFFFFFF, 0, 0, 255, 0), 1, '{0, 0, 0, 0, 2});
    add_row(mk(OP_ADD_DISC, 0, 0, 0, 7, 0), 1, '{0, 0, 0, 0, 2});
    add_row(mk(OP_FIND, 0, 0, 0, 0, 0), 1, '{0, 1, 0, 0, 2});
    add_row(mk(OP_FIND, 0, 0, 0, 0, 24'hFFFFFF), 1, '{24'hFFFFFF, 1, 255, 0, 2});
    add_row(mk(OP_ADD_RNG, 0, 24'hFFFFFF, 0, 3, 0), 1, '{0, 0, 0, 0, 12});
    add_row(mk(OP_ADD_RNG, 800000, 1000, 0, 3, 0), 1, '{0, 0, 0, 0, 12});
    add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 0});
    add_row(mk(OP_ADD_RNG, 44100, 800000, 44100, 9, 0), 0, '0);
    add_row(mk(OP_ADD_RNG, 48000, 48000, 24'hFFFFFF, 4, 0), 0, '0);
    add_row(mk(OP_ADD_DISC, 50000, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_FIND, 0, 0, 0, 0, 46050), 0, '0);
    add_row(mk(OP_FIND, 0, 0, 0, 0, 49000), 0, '0);
    add_row(mk(OP_FIND, 0, 0, 0, 0, 50000), 0, '0);
    add_row(mk(OP_FIND, 0, 0, 0, 0, 1), 0, '0);
    foreach (dir_rows[i]) begin
      void'(predict_rate_result(dir_rows[i].cmd));
    end
    // Rerun the predictor from the same state as the block.
    tbl_count = 0;
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, $urandom_range(0, 2));
      if (dir_rows[i].typed && pending_results[$] !== dir_rows[i].want) begin
        errors++;
        if (mismatches++ < 10) $display("directed row %0d predicts %h", i, pending_results[$]);
      end
    end
    in_ch.valid <= 1'b0;
    drain_results();

    // Default clock id and fill to a full table with id zero entries.
    write_default_clock(8'hFF);
    send_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0), 0);
    for (int i = 0; i < SRTS_TABLE_DEPTH + 2; i++)
      send_cmd(mk(OP_ADD_DISC, 1000 * (i + 1), 0, 0, 0, 0), 0);
    send_cmd(mk(OP_ADD_RNG, 0, 24'hFFFFFF, 0, 1, 0), 0);
    send_cmd(mk(OP_FIND, 0, 0, 0, 0, 2500), 0);
    in_ch.valid <= 1'b0;
    drain_results();

    // Random phases across several default clock settings.
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_default_clock(ph == 0 ? 8'h00 : ph == 1 ? 8'h5A : 8'($urandom()));
      rx_stall_mode = ph[0];
      send_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0), 0);
      while (sent < (ph + 1) * 285) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) begin
          c = random_cmd();
          send_cmd(c, (b == 0) ? $urandom_range(1, 6) : 0);
          sent++;
        end
      end
      in_ch.valid <= 1'b0;
      drain_results();
    end

    if (errors == 0) begin
      $display("sample_rate_table_select_top verification clean");
    end else begin
      $display("sample_rate_table_select_top verification failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("sample_rate_table_select_top verification failed");
    $finish;
  end

endmodule

[sim.f]
design/srts_pkg.sv
design/srts_if.sv
design/srts_div.sv
design/srts_mem.sv
design/sample_rate_table_select_top.sv
sim/srts_tb_if.sv
sim/sample_rate_table_select_top_tb.sv
